@@ design/cht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared constants, action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int DefBuckets   = 256;
   localparam int DefPoolNodes = 256;
   localparam int DefKeyBits   = 64;
   localparam int DefValueBits = 64;

   localparam int ActionBits = 3;
   localparam int HashBits   = 32;
   localparam int FieldBits  = 64;
   localparam int StatusBits = 2;
   localparam int CountBits  = 10;
   localparam int CfgBits    = 9;

   typedef enum logic [ActionBits-1:0] {
      ACT_PUT        = 3'd0,
      ACT_PUT_UNIQUE = 3'd1,
      ACT_GET        = 3'd2,
      ACT_DELETE     = 3'd3,
      ACT_GET_DELETE = 3'd4
   } action_type;

   typedef enum logic [StatusBits-1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_PRESENT = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_HREAD,
      S_HWAIT,
      S_HCHK,
      S_NWAIT,
      S_NCHK,
      S_FWAIT,
      S_ACT,
      S_SWAIT,
      S_SUCC,
      S_DONE
   } state_type;

endpackage : cht_pkg
`default_nettype wire

@@ design/cht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : cht_ram
`default_nettype wire

@@ design/chained_hash_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table core
// Key/value table with a head slot per bucket and a chained overflow pool.
//
//   channel  ports                               transfer
//   request  req_action/hash_value/key/new_value start high, busy low
//   response rsp_status/read_value/entry_total   rsp_valid high, one cycle
//   config   csr_wr_en, csr_wr_data              csr_wr_en high
//
// A request keeps busy high through the hash reduction (one quotient bit
// per cycle), the head read and check, a read and check per chain node,
// then the update and the result strobe. A deleted head that takes in its
// successor adds a fetch of that successor and a rewrite of the head.
// Each memory port allows one access per cycle. The receiver cannot stall.
// After reset, a clearing pass over the larger of BUCKETS and POOL_NODES
// addresses empties the head links and loads the free stack; start is refused
// until it ends.
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
   parameter int BUCKETS    = cht_pkg::DefBuckets,
   parameter int POOL_NODES = cht_pkg::DefPoolNodes,
   parameter int KEY_BITS   = cht_pkg::DefKeyBits,
   parameter int VALUE_BITS = cht_pkg::DefValueBits
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [cht_pkg::ActionBits-1:0]   req_action,
   input  wire logic [cht_pkg::HashBits-1:0]     req_hash_value,
   input  wire logic [cht_pkg::FieldBits-1:0]    req_key,
   input  wire logic [cht_pkg::FieldBits-1:0]    req_new_value,
   output logic                                  rsp_valid,
   output logic      [cht_pkg::StatusBits-1:0]   rsp_status,
   output logic      [cht_pkg::FieldBits-1:0]    rsp_read_value,
   output logic      [cht_pkg::CountBits-1:0]    rsp_entry_total,
   input  wire logic                             csr_wr_en,
   input  wire logic [cht_pkg::CfgBits-1:0]      csr_wr_data
);
   import cht_pkg::*;

   localparam int BW  = $clog2(BUCKETS);
   localparam int PW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int LW  = $clog2(POOL_NODES + 1);
   localparam int FTW = $clog2(POOL_NODES + 1);
   localparam int MW  = $clog2(BUCKETS + 1);
   localparam int CW  = $clog2(POOL_NODES + 2);
   localparam int HRW = KEY_BITS + VALUE_BITS + LW;
   localparam int NRW = KEY_BITS + VALUE_BITS + LW;
   localparam int CLR = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
   localparam int CLW = $clog2(CLR + 1);

   // Configuration and request registers.
   logic [CfgBits-1:0]    bcount_ff;
   state_type             state_ff, state_in;
   action_type            act_ff;
   logic                  act_known_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [HashBits-1:0]   rem_ff;
   logic [5:0]            mcnt_ff;
   logic [BW-1:0]         bucket_ff;
   logic [MW-1:0]         modulus;

   // Walk registers.
   logic [LW-1:0]         cur_ff, cur_in, prev_ff, prev_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic                  found_ff, found_in;
   logic [HRW-1:0]        head_ff;
   logic [NRW-1:0]        node_ff;
   logic [NRW-1:0]        pnode_ff;
   logic [FTW-1:0]        free_total_ff, free_total_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [PW-1:0]         newn_ff;
   logic [CLW-1:0]        clr_ff;
   logic                  clr_busy;

   // Valid bits per bucket.
   logic [BUCKETS-1:0]    hvalid_ff;
   logic                  hv_set, hv_clr;

   // Memory ports.
   logic            h_we, n_we, f_we;
   logic [BW-1:0]   h_wa, h_ra;
   logic [HRW-1:0]  h_wd, h_rd;
   logic [PW-1:0]   n_wa, n_ra, f_wa, f_ra;
   logic [NRW-1:0]  n_wd, n_rd;
   logic [PW-1:0]   f_wd, f_rd;

   // Response registers.
   logic                   rsp_valid_in;
   logic [StatusBits-1:0]  status_in;
   logic [FieldBits-1:0]   rv_in;

   cht_ram #(.Width(HRW), .Depth(BUCKETS)) u_head (
      .clock, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd), .rd_addr(h_ra), .rd_data(h_rd));
   cht_ram #(.Width(NRW), .Depth(POOL_NODES)) u_node (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd), .rd_addr(n_ra), .rd_data(n_rd));
   cht_ram #(.Width(PW), .Depth(POOL_NODES)) u_free (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));

   // Field views of the records (key, value, link from top).
   logic [KEY_BITS-1:0]   hk, nk;
   logic [VALUE_BITS-1:0] hval, nval;
   logic [LW-1:0]         hl, nl;
   assign hk   = head_ff[HRW-1 -: KEY_BITS];
   assign hval = head_ff[LW +: VALUE_BITS];
   assign hl   = head_ff[LW-1:0];
   assign nk   = node_ff[NRW-1 -: KEY_BITS];
   assign nval = node_ff[LW +: VALUE_BITS];
   assign nl   = node_ff[LW-1:0];

   // Effective modulus: zero acts as one, saturated to the bucket count.
   always_comb begin
      if (bcount_ff == '0) begin
         modulus = MW'(1);
      end else if (32'(bcount_ff) > 32'(BUCKETS)) begin
         modulus = MW'(BUCKETS);
      end else begin
         modulus = MW'(bcount_ff);
      end
   end

   // One restoring-division step per cycle over the hash bits.
   logic [MW:0]  trial;
   logic [MW-1:0] part_ff;
   always_comb begin
      trial = {part_ff, rem_ff[HashBits-1]} - {1'b0, modulus};
   end

   assign clr_busy = (clr_ff != CLW'(CLR));
   assign busy     = (state_ff != S_IDLE) || clr_busy;

   logic link_ok_h, link_ok_n;
   assign link_ok_h = (hl != '0) && (32'(hl) <= 32'(POOL_NODES));
   assign link_ok_n = (nl != '0) && (32'(nl) <= 32'(POOL_NODES));

   logic [PW-1:0] cur_idx, nl_idx;
   assign cur_idx = PW'(cur_ff - LW'(1));
   assign nl_idx  = PW'(hl - LW'(1));

   logic hvalid_b;
   assign hvalid_b = hvalid_ff[bucket_ff];

   // Sequencer: next state, memory ports and result.
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff; prev_in = prev_ff; steps_in = steps_ff; found_in = found_ff;
      free_total_in = free_total_ff; count_in = count_ff;
      h_we = 1'b0; h_wa = bucket_ff; h_wd = head_ff; h_ra = bucket_ff;
      n_we = 1'b0; n_wa = cur_idx; n_wd = node_ff; n_ra = cur_idx;
      f_we = 1'b0; f_wa = PW'(free_total_ff); f_wd = cur_idx;
      f_ra = PW'(free_total_ff - FTW'(1));
      hv_set = 1'b0; hv_clr = 1'b0;
      rsp_valid_in = 1'b0; status_in = ST_OK; rv_in = '0;
      if (clr_busy) begin
         h_we = (32'(clr_ff) < 32'(BUCKETS));
         h_wa = BW'(clr_ff);
         h_wd = '0;
         f_we = (32'(clr_ff) < 32'(POOL_NODES));
         f_wa = PW'(clr_ff);
         f_wd = PW'(clr_ff);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start && !clr_busy) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mcnt_ff == 6'(HashBits - 1)) begin
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            // The remainder is final here; address the head slot with it.
            h_ra = BW'(part_ff);
            cur_in = '0; prev_in = '0; steps_in = '0; found_in = 1'b0;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (!hvalid_b) begin
               state_in = S_FWAIT;
            end else if (hk == key_ff) begin
               found_in = 1'b1;
               state_in = S_FWAIT;
            end else if (!link_ok_h) begin
               state_in = S_FWAIT;
            end else begin
               cur_in = hl;
               n_ra = nl_idx;
               state_in = S_NWAIT;
            end
         end
         S_NWAIT: begin
            state_in = S_NCHK;
         end
         S_NCHK: begin
            steps_in = steps_ff + CW'(1);
            if (nk == key_ff) begin
               found_in = 1'b1;
               state_in = S_FWAIT;
            end else if (!link_ok_n || steps_ff == CW'(POOL_NODES - 1)) begin
               state_in = S_FWAIT;
            end else begin
               prev_in = cur_ff;
               cur_in = nl;
               n_ra = PW'(nl - LW'(1));
               state_in = S_NWAIT;
            end
         end
         S_FWAIT: begin
            state_in = S_ACT;
         end
         S_ACT: begin
            state_in = S_DONE;
            rsp_valid_in = 1'b1;
            if (!act_known_ff) begin
               status_in = ST_OK;
            end else begin
               case (act_ff) inside
                  ACT_PUT, ACT_PUT_UNIQUE: begin
                     if (found_ff) begin
                        if (act_ff == ACT_PUT) begin
                           if (cur_ff == '0) begin
                              h_we = 1'b1; h_wd = {hk, val_ff, hl};
                           end else begin
                              n_we = 1'b1; n_wd = {nk, val_ff, nl};
                           end
                        end else begin
                           status_in = ST_PRESENT;
                        end
                     end else if (!hvalid_b) begin
                        h_we = 1'b1; h_wd = {key_ff, val_ff, LW'(0)};
                        hv_set = 1'b1;
                        count_in = count_ff + CountBits'(1);
                     end else if (free_total_ff == '0) begin
                        status_in = ST_FULL;
                     end else begin
                        free_total_in = free_total_ff - FTW'(1);
                        n_we = 1'b1; n_wa = newn_ff; n_wd = {key_ff, val_ff, hl};
                        h_we = 1'b1; h_wd = {hk, hval, LW'(newn_ff) + LW'(1)};
                        count_in = count_ff + CountBits'(1);
                     end
                  end
                  ACT_GET: begin
                     if (found_ff) begin
                        rv_in = FieldBits'((cur_ff == '0) ? hval : nval);
                     end else begin
                        status_in = ST_MISSING;
                     end
                  end
                  ACT_DELETE, ACT_GET_DELETE: begin
                     if (!found_ff) begin
                        status_in = ST_MISSING;
                     end else begin
                        if (act_ff == ACT_GET_DELETE) begin
                           rv_in = FieldBits'((cur_ff == '0) ? hval : nval);
                        end
                        if (count_ff != '0) begin
                           count_in = count_ff - CountBits'(1);
                        end
                        if (cur_ff != '0) begin
                           if (prev_ff == '0) begin
                              h_we = 1'b1; h_wd = {hk, hval, nl};
                           end else begin
                              n_we = 1'b1; n_wa = PW'(prev_ff - LW'(1));
                              n_wd = {pnode_ff[NRW-1:LW], nl};
                           end
                           if (32'(free_total_ff) < 32'(POOL_NODES)) begin
                              f_we = 1'b1; f_wd = cur_idx;
                              free_total_in = free_total_ff + FTW'(1);
                           end
                        end else if (!link_ok_h) begin
                           hv_clr = 1'b1;
                           h_we = 1'b1; h_wd = {hk, hval, LW'(0)};
                        end else begin
                           // Head takes in its successor; fetch it first.
                           rsp_valid_in = 1'b0;
                           n_ra = nl_idx;
                           state_in = S_SWAIT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SWAIT: begin
            state_in = S_SUCC;
         end
         S_SUCC: begin
            h_we = 1'b1; h_wd = node_ff;
            if (32'(free_total_ff) < 32'(POOL_NODES)) begin
               f_we = 1'b1; f_wd = nl_idx;
               free_total_in = free_total_ff + FTW'(1);
            end
            rsp_valid_in = 1'b1;
            rv_in = (act_ff == ACT_GET_DELETE) ? FieldBits'(hval) : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bcount_ff     <= CfgBits'(256);
         hvalid_ff     <= '0;
         free_total_ff <= FTW'(POOL_NODES);
         count_ff      <= '0;
         clr_ff        <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_total_ff <= free_total_in;
         count_ff      <= count_in;
         rsp_valid     <= rsp_valid_in;
         if (clr_busy) begin
            clr_ff <= clr_ff + CLW'(1);
         end
         if (csr_wr_en) begin
            bcount_ff <= csr_wr_data;
         end
         if (hv_set) begin
            hvalid_ff[bucket_ff] <= 1'b1;
         end else if (hv_clr) begin
            hvalid_ff[bucket_ff] <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      found_ff <= found_in;
      rsp_status     <= status_in;
      rsp_read_value <= rv_in;
      rsp_entry_total <= count_in;
      if (state_ff == S_IDLE) begin
         act_ff       <= action_type'(req_action);
         act_known_ff <= (req_action <= ActionBits'(ACT_GET_DELETE));
         key_ff       <= req_key[KEY_BITS-1:0];
         val_ff       <= req_new_value[VALUE_BITS-1:0];
         rem_ff       <= req_hash_value;
         part_ff      <= '0;
         mcnt_ff      <= '0;
      end else if (state_ff == S_MOD) begin
         mcnt_ff <= mcnt_ff + 6'd1;
         rem_ff  <= {rem_ff[HashBits-2:0], 1'b0};
         if (!trial[MW]) begin
            part_ff <= trial[MW-1:0];
         end else begin
            part_ff <= {part_ff[MW-2:0], rem_ff[HashBits-1]};
         end
      end
      if (state_ff == S_HREAD) begin
         bucket_ff <= BW'(part_ff);
      end
      if (state_ff == S_HCHK) begin
         newn_ff <= f_rd;
      end
      // Head record arrives in the cycle after its read address is set.
      if (state_ff == S_HWAIT) begin
         head_ff <= h_rd;
      end
      // Keep the predecessor only when the walk moves on.
      if (state_ff == S_NCHK && state_in == S_NWAIT) begin
         pnode_ff <= node_ff;
      end
      if (state_ff == S_NWAIT || state_ff == S_SWAIT) begin
         node_ff <= n_rd;
      end
   end

   // Checks.
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside a request");
   a_free_max: assert property (@(posedge clock) disable iff (reset)
      32'(free_total_ff) <= 32'(POOL_NODES)) else $error("free count overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> $stable(count_ff))
      else $error("count changed on a failed request");

endmodule : chained_hash_table_core
`default_nettype wire
